// ----- src/ook_manchester_word_packer_defines.svh -----
// assertion macros for the ook manchester word packer checker
// no dependencies; taken in by `include where assertions are written
`ifndef OOK_MANCHESTER_WORD_PACKER_DEFINES_SVH
`define OOK_MANCHESTER_WORD_PACKER_DEFINES_SVH

// same-cycle implication, off while in reset
`define OMWP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("omwp assertion failed");

// next-cycle implication, off while in reset
`define OMWP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("omwp assertion failed");

// next-cycle implication that also holds through reset
`define OMWP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("omwp assertion failed");

`endif

// ----- src/omwp_pkg.sv -----
// shared types, constants and the manchester expansion for the word packer
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package omwp_pkg;

  localparam int WORD_W     = 32;
  localparam int SYM_W      = 16;
  localparam int COUNT_W    = 16;
  localparam int FILL_W     = 5;
  localparam int NSYM_W     = 6;
  localparam int PREAMBLE_W = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET = 4'd3;
  localparam logic [PREAMBLE_W-1:0] BYTES_SEEN_MAX = 4'd15;
  localparam logic [COUNT_W-1:0]    COUNT_MAX      = 16'hFFFF;
  localparam logic [NSYM_W-1:0]     RAW_SYMS       = 6'd8;
  localparam logic [NSYM_W-1:0]     MAN_SYMS       = 6'd16;

  // register index, taken from paddr bit 2
  localparam logic REG_PREAMBLE = 1'b0;

  typedef struct packed {
    logic [SYM_W-1:0] symbols;  // left aligned, first symbol in the msb
    logic             manch;    // 16 symbols when set, else 8
    logic             last;
  } sym_entry_t;

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] total;
    logic               last;
  } result_t;

  // 1 -> low-high, 0 -> high-low, msb first
  function automatic logic [SYM_W-1:0] manchester_expand(input logic [7:0] b);
    logic [SYM_W-1:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s[2*i+1] = ~b[i];
      s[2*i]   = b[i];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- src/omwp_front.sv -----
// front end: accepts frame bytes and turns each into a symbol group
// depends on omwp_pkg
`timescale 1ns / 1ps
`default_nettype none

module omwp_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [7:0]                           data_byte,
  input  wire logic                                 last_byte,
  input  wire logic [omwp_pkg::PREAMBLE_W-1:0]      preamble_bytes,
  input  wire logic                                 q_ready,
  output logic                                      q_push,
  output omwp_pkg::sym_entry_t                      q_entry
);

  logic [omwp_pkg::PREAMBLE_W-1:0] bytes_seen;
  logic [omwp_pkg::PREAMBLE_W-1:0] bytes_seen_next;
  logic                            raw;

  always_comb begin
    raw              = bytes_seen < preamble_bytes;
    q_entry.symbols  = raw ? {data_byte, 8'h00} : omwp_pkg::manchester_expand(data_byte);
    q_entry.manch    = !raw;
    q_entry.last     = last_byte;
    in_ready         = q_ready;
    q_push           = in_valid && q_ready;
  end

  // byte position in the frame, saturating
  always_comb begin
    bytes_seen_next = bytes_seen;
    if (q_push) begin
      if (last_byte) begin
        bytes_seen_next = '0;
      end else if (bytes_seen != omwp_pkg::BYTES_SEEN_MAX) begin
        bytes_seen_next = bytes_seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else begin
      bytes_seen <= bytes_seen_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/omwp_queue.sv -----
// short queue of symbol groups between front and back end
// depends on omwp_pkg
`timescale 1ns / 1ps
`default_nettype none

module omwp_queue #(
  parameter int DEPTH = omwp_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire omwp_pkg::sym_entry_t  push_entry,
  output logic                       push_ready,
  input  wire logic                  pop,
  output logic                       pop_valid,
  output omwp_pkg::sym_entry_t       pop_entry
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  omwp_pkg::sym_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/omwp_back.sv -----
// back end: packs symbol groups into 32-bit words, counts symbols, flushes
// depends on omwp_pkg
`timescale 1ns / 1ps
`default_nettype none

module omwp_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_valid,
  input  wire omwp_pkg::sym_entry_t  q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output omwp_pkg::result_t          out_res
);

  localparam int W = omwp_pkg::WORD_W;
  localparam int S = omwp_pkg::SYM_W;
  localparam int C = omwp_pkg::COUNT_W;

  logic [W-1:0]                    pack_word;
  logic [omwp_pkg::FILL_W-1:0]     fill_count;
  logic [C-1:0]                    symbol_counter;
  logic                            pend_valid;
  omwp_pkg::result_t               pend_res;

  logic [W+S-1:0]                  ext;
  logic [omwp_pkg::NSYM_W-1:0]     nsym;
  logic [omwp_pkg::NSYM_W-1:0]     new_fill;
  logic                            full;
  logic [W-1:0]                    pack_next;
  logic [C:0]                      count_sum;
  logic [C-1:0]                    count_next;
  logic                            has_result;
  logic                            out_free;

  always_comb begin
    nsym       = q_entry.manch ? omwp_pkg::MAN_SYMS : omwp_pkg::RAW_SYMS;
    ext        = {pack_word, {S{1'b0}}} | ({q_entry.symbols, {W{1'b0}}} >> fill_count);
    new_fill   = {1'b0, fill_count} + nsym;
    full       = new_fill[omwp_pkg::NSYM_W-1];
    pack_next  = full ? {ext[S-1:0], {(W-S){1'b0}}} : ext[W+S-1:S];
    // the appended zero symbol also counts
    count_sum  = {1'b0, symbol_counter} + (C+1)'(nsym) + (C+1)'(q_entry.last);
    count_next = count_sum[C] ? omwp_pkg::COUNT_MAX : count_sum[C-1:0];
    has_result = full || q_entry.last;
    out_free   = !out_valid || out_ready;
    q_pop      = q_valid && !pend_valid && (out_free || !has_result);
  end

  // packing state
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_word      <= '0;
      fill_count     <= '0;
      symbol_counter <= '0;
    end else if (q_pop) begin
      if (q_entry.last) begin
        pack_word      <= '0;
        fill_count     <= '0;
        symbol_counter <= '0;
      end else begin
        pack_word      <= pack_next;
        fill_count     <= new_fill[omwp_pkg::FILL_W-1:0];
        symbol_counter <= count_next;
      end
    end
  end

  // output register plus one holding slot for the final word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else if (q_pop && has_result) begin
        out_valid  <= 1'b1;
        pend_valid <= full && q_entry.last;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        out_res <= pend_res;
      end else if (q_pop && has_result) begin
        out_res.word  <= full ? ext[W+S-1:S] : pack_next;
        out_res.total <= full ? '0 : count_next;
        out_res.last  <= !full;
        pend_res.word  <= pack_next;
        pend_res.total <= count_next;
        pend_res.last  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/ook_manchester_word_packer.sv -----
// top level of the ook manchester word packer: config register and wiring
// depends on omwp_pkg, omwp_front, omwp_queue, omwp_back
`timescale 1ns / 1ps
`default_nettype none

// usage
//   input channel: one frame byte per transaction (data_byte, last_byte),
//     accepted when in_valid and in_ready are both high
//   output channel: one packed 32-bit word per transaction (out_word,
//     symbol_total, last_word), taken when out_valid and out_ready are high
//   config: apb write to preamble_bytes at byte address 0, pready tied high;
//     write only while no frame is in flight
// an accepted byte is registered in the queue; the word that it completes
//   is then registered in the output register before it can be taken
// throughput: one byte per cycle while the queue has room; a final byte that
//   also fills a word gives two words, sent in turn as the back end holds off
// the front end classifies bytes (raw preamble or manchester) and expands them;
//   a short queue lets it keep accepting while the back end waits on the output
// reset: frame state clears, preamble_bytes returns to 3, nothing is output
// receiver stall: the output word holds; the queue fills and then in_ready drops
module ook_manchester_word_packer #(
  parameter int QUEUE_DEPTH = omwp_pkg::QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // byte input
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [7:0]                         data_byte,
  input  wire logic                               last_byte,
  // word output
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [omwp_pkg::WORD_W-1:0]             out_word,
  output logic [omwp_pkg::COUNT_W-1:0]            symbol_total,
  output logic                                    last_word,
  // apb config port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [omwp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [omwp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [omwp_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                    pready
);

  logic [omwp_pkg::PREAMBLE_W-1:0] preamble_bytes;
  logic                            reg_index;
  logic                            cfg_write;

  logic                            q_push;
  logic                            q_ready;
  omwp_pkg::sym_entry_t            q_in;
  logic                            q_pop;
  logic                            q_valid;
  omwp_pkg::sym_entry_t            q_out;
  omwp_pkg::result_t               res;

  // register index is the word address
  assign reg_index = paddr[omwp_pkg::CFG_ADDR_W-1];
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (reg_index == omwp_pkg::REG_PREAMBLE) begin
      prdata = omwp_pkg::CFG_DATA_W'(preamble_bytes);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_bytes <= omwp_pkg::PREAMBLE_RESET;
    end else if (cfg_write && reg_index == omwp_pkg::REG_PREAMBLE) begin
      preamble_bytes <= pwdata[omwp_pkg::PREAMBLE_W-1:0];
    end
  end

  omwp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .preamble_bytes (preamble_bytes),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_entry        (q_in)
  );

  omwp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (q_out)
  );

  omwp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_word     = res.word;
  assign symbol_total = res.total;
  assign last_word    = res.last;

endmodule

`default_nettype wire

// ----- src/omwp_checker.sv -----
// port-level checker for the word packer, bound to the top level
// depends on ook_manchester_word_packer_defines.svh and ook_manchester_word_packer
`timescale 1ns / 1ps
`default_nettype none

`include "ook_manchester_word_packer_defines.svh"

module omwp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_word,
  input wire logic [15:0] symbol_total,
  input wire logic        last_word
);

  // coming out of reset the block is empty and ready
  `OMWP_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, in_ready && !out_valid)

  // only the final word carries a symbol count
  `OMWP_ASSERT_NOW(a_total_only_last, clk, rst, out_valid && !last_word, symbol_total == '0)

  // a frame has at least one byte plus the extra symbol
  `OMWP_ASSERT_NOW(a_last_total_min, clk, rst, out_valid && last_word, symbol_total >= 16'd9)

  // stalled word holds
  `OMWP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(out_word) && $stable(symbol_total) && $stable(last_word))

endmodule

bind ook_manchester_word_packer omwp_checker u_omwp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_word     (out_word),
  .symbol_total (symbol_total),
  .last_word    (last_word)
);

`default_nettype wire
